// ===== src/mp2_pkg.sv =====
// Shared types and constants for the 2-D mean pooling block.
// No dependencies; imported by mp2_store, mean_pooling_2d and the testbench.
package mp2_pkg;

    localparam int IN_W        = 32;
    localparam int OUT_W       = 32;
    localparam int WS_CFG_W    = 4;
    localparam int DIM_W       = 11;
    localparam int ROW_W       = 10;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int HEIGHT_LIMIT = 1024;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [WS_CFG_W-1:0] WINDOW_SIZE_RST  = 4'd2;
    localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RST = 11'd1024;

    // Control of one read-modify-write on the row store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic first;
    } t_acc_ctrl;

endpackage

// ===== src/mp2_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by setup and result paths of the pooling top.
module mp2_div #(
    parameter int QW = 32,
    parameter int DV = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [QW-1:0] i_dividend,
    input  logic [DV-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [QW-1:0] o_quotient,
    output logic [DV-1:0] o_remainder
);

    localparam int CNW = $clog2(QW + 1);

    logic [QW-1:0]  r_quo;
    logic [DV-1:0]  r_rem;
    logic [DV-1:0]  r_dsr;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [DV:0]    w_shift;
    logic [DV:0]    w_diff;
    logic           w_take;
    logic [QW-1:0]  n_quo;
    logic [DV-1:0]  n_rem;

    always_comb begin
        w_shift = {r_rem, r_quo[QW-1]};
        w_diff  = w_shift - {1'b0, r_dsr};
        w_take  = (w_shift >= {1'b0, r_dsr});
        n_rem   = w_take ? w_diff[DV-1:0] : w_shift[DV-1:0];
        n_quo   = {r_quo[QW-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== src/mp2_store.sv =====
// Row store of per-output-column partial sums with read-modify-write accumulate.
// Depends on mp2_pkg (t_acc_ctrl); read data is registered.
module mp2_store
    import mp2_pkg::*;
#(
    parameter  int DATA_WIDTH = 32,
    parameter  int DEPTH      = 1024,
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  t_acc_ctrl             i_ctrl,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_sample,
    output logic [DATA_WIDTH-1:0] o_sum
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // restart the sum on the first sample of a window
    assign o_sum = i_ctrl.first ? i_sample : r_rd_data + i_sample;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= o_sum;
        end
    end

endmodule

// ===== src/mean_pooling_2d.sv =====
// 2-D mean pooling over non-overlapping square windows, streaming top level.
// Depends on mp2_pkg, mp2_store (row store) and mp2_div (shared divider).
//
// Usage:
//   Samples enter in raster order on the input channel (i_in_valid /
//   o_in_ready, payload i_sample_value). One pooled mean leaves per whole
//   window on the output channel (o_out_valid / i_out_ready), in raster
//   order of the pooled image, with o_frame_last on the final one.
//   The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) writes
//   window_size, image_width and image_height; write only while idle.
// Timing:
//   A sample inside a whole window is taken in ST_IDLE, which issues the row
//   store read, and ST_ADD then adds and writes back; other samples skip
//   ST_ADD. A sample that closes a window starts the serial divider, QW =
//   max(DATA_WIDTH, 13) bits wide; its mean then loads the output register.
//   One division runs at a time, so a second window close waits for it.
// Reset and setup:
//   After reset and after every configuration write the block runs the
//   divider three times to derive the used width/height and the output
//   column; o_in_ready stays low meanwhile.
// Backpressure:
//   A finished mean waits in the divider until the output register frees;
//   samples keep being accepted, only the next window close stalls behind it.
module mean_pooling_2d
    import mp2_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [IN_W-1:0]      i_sample_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [OUT_W-1:0]     o_mean_value,
    output logic                        o_frame_last
);

    localparam int DW  = DATA_WIDTH;
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PHW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WSW = $clog2(MAX_WINDOW + 1);
    localparam int DV  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int XW  = 13;
    localparam int QW  = (DATA_WIDTH > XW) ? DATA_WIDTH : XW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;

    localparam logic [1:0] JOB_COLS = 2'd0;
    localparam logic [1:0] JOB_ROWS = 2'd1;
    localparam logic [1:0] JOB_COL  = 2'd2;
    localparam logic [1:0] JOB_MEAN = 2'd3;

    // configuration
    logic [WS_CFG_W-1:0] r_cfg_ws;
    logic [DIM_W-1:0]    r_cfg_w;
    logic [DIM_W-1:0]    r_cfg_h;
    logic                r_dirty;

    // position and derived limits
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [PHW-1:0]   r_cphase;
    logic [PHW-1:0]   r_rphase;
    logic [CW-1:0]    r_oc;
    logic [PHW-1:0]   r_cmod;
    logic [DIM_W-1:0] r_cols_used;
    logic [DIM_W-1:0] r_rows_used;

    logic [1:0]       r_state;
    logic [1:0]       r_div_job;
    logic             r_div_neg;
    logic             r_div_flast;
    logic             r_mean_pend;

    // sample held for the add cycle
    logic [DW-1:0]    r_x;
    logic [CW-1:0]    r_addr;
    logic             r_first;
    logic             r_last;
    logic             r_flast;

    logic                   r_out_valid;
    logic signed [OUT_W-1:0] r_out_mean;
    logic                   r_out_last;

    logic [WSW-1:0]   w_ws;
    logic [DIM_W-1:0] w_w;
    logic [DIM_W-1:0] w_h;
    logic [DV-1:0]    w_area;
    logic [PHW-1:0]   w_cp;
    logic [PHW-1:0]   w_rp;
    logic             w_accept;
    logic             w_use;
    logic             w_first;
    logic             w_last;
    logic             w_flast;
    logic [DW-1:0]    w_x;

    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic [PHW-1:0]   n_cphase;
    logic [PHW-1:0]   n_rphase;
    logic [CW-1:0]    n_oc;
    logic [PHW-1:0]   n_cmod;

    logic             w_div_start;
    logic [1:0]       n_div_job;
    logic [QW-1:0]    w_div_dividend;
    logic [DV-1:0]    w_div_divisor;
    logic             w_div_busy;
    logic             w_div_done;
    logic [QW-1:0]    w_div_q;
    logic [DV-1:0]    w_div_r;
    logic             w_div_avail;
    logic             w_add_go;
    logic             w_out_free;

    t_acc_ctrl        w_acc;
    logic [DW-1:0]    w_sum;
    logic [DW-1:0]    w_mag;
    logic [DW-1:0]    w_q_dw;
    logic signed [DW-1:0] w_mean_dw;

    // Clamp the raw registers to their legal ranges.
    always_comb begin
        if (r_cfg_ws == '0) begin
            w_ws = WSW'(1);
        end else if (5'(r_cfg_ws) > 5'(MAX_WINDOW)) begin
            w_ws = WSW'(MAX_WINDOW);
        end else begin
            w_ws = WSW'(r_cfg_ws);
        end
        if (r_cfg_w == '0) begin
            w_w = DIM_W'(1);
        end else if (XW'(r_cfg_w) > XW'(MAX_WIDTH)) begin
            w_w = DIM_W'(MAX_WIDTH);
        end else begin
            w_w = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            w_h = DIM_W'(1);
        end else if (XW'(r_cfg_h) > XW'(HEIGHT_LIMIT)) begin
            w_h = DIM_W'(HEIGHT_LIMIT);
        end else begin
            w_h = r_cfg_h;
        end
        w_area = DV'(w_ws) * DV'(w_ws);
    end

    // Classify the incoming sample and work out the next position.
    always_comb begin
        w_x  = DW'(i_sample_value);
        w_cp = (WSW'(r_cphase) >= w_ws) ? '0 : r_cphase;
        w_rp = (WSW'(r_rphase) >= w_ws) ? '0 : r_rphase;

        w_use   = (XW'(r_col) < XW'(r_cols_used)) && (XW'(r_row) < XW'(r_rows_used));
        w_first = (w_cp == '0) && (w_rp == '0);
        w_last  = (WSW'(w_cp) == w_ws - 1'b1) && (WSW'(w_rp) == w_ws - 1'b1);
        w_flast = (XW'(r_col) == XW'(r_cols_used) - 1'b1) &&
                  (XW'(r_row) == XW'(r_rows_used) - 1'b1);

        n_row    = r_row;
        n_rphase = w_rp;
        if (XW'(r_col) >= XW'(w_w) - 1'b1) begin
            n_col    = '0;
            n_cphase = '0;
            n_oc     = '0;
            n_cmod   = '0;
            if (XW'(r_row) >= XW'(w_h) - 1'b1) begin
                n_row    = '0;
                n_rphase = '0;
            end else begin
                n_row    = r_row + 1'b1;
                n_rphase = (WSW'(w_rp) + 1'b1 >= w_ws) ? '0 : w_rp + 1'b1;
            end
        end else begin
            n_col    = r_col + 1'b1;
            n_cphase = (WSW'(w_cp) + 1'b1 >= w_ws) ? '0 : w_cp + 1'b1;
            if (WSW'(r_cmod) + 1'b1 == w_ws) begin
                n_cmod = '0;
                n_oc   = r_oc + 1'b1;
            end else begin
                n_cmod = r_cmod + 1'b1;
                n_oc   = r_oc;
            end
        end
    end

    assign o_in_ready = (r_state == ST_IDLE) && !r_dirty;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Divider is free for a new job only once the last mean has left it.
    assign w_div_avail = !w_div_busy && !w_div_done && !r_mean_pend;
    assign w_add_go    = (r_state == ST_ADD) && (!r_last || w_div_avail);

    assign w_mag = w_sum[DW-1] ? DW'(-w_sum) : w_sum;

    // Divider job selection: setup chain, then window means.
    always_comb begin
        w_div_start    = 1'b0;
        n_div_job      = r_div_job;
        w_div_dividend = '0;
        w_div_divisor  = DV'(w_ws);
        case (r_state)
            ST_IDLE: begin
                if (r_dirty && w_div_avail) begin
                    w_div_start    = 1'b1;
                    n_div_job      = JOB_COLS;
                    w_div_dividend = QW'(w_w);
                end
            end
            ST_PREP: begin
                if (w_div_done && r_div_job == JOB_COLS) begin
                    w_div_start    = 1'b1;
                    n_div_job      = JOB_ROWS;
                    w_div_dividend = QW'(w_h);
                end else if (w_div_done && r_div_job == JOB_ROWS) begin
                    w_div_start    = 1'b1;
                    n_div_job      = JOB_COL;
                    w_div_dividend = QW'(r_col);
                end
            end
            ST_ADD: begin
                if (r_last && w_div_avail) begin
                    w_div_start    = 1'b1;
                    n_div_job      = JOB_MEAN;
                    w_div_dividend = QW'(w_mag);
                    w_div_divisor  = w_area;
                end
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_acc.rd_en = w_accept && w_use;
        w_acc.wr_en = w_add_go;
        w_acc.first = r_first;
    end

    mp2_store #(
        .DATA_WIDTH (DW),
        .DEPTH      (MAX_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctrl    (w_acc),
        .i_rd_addr (r_oc),
        .i_wr_addr (r_addr),
        .i_sample  (r_x),
        .o_sum     (w_sum)
    );

    mp2_div #(
        .QW (QW),
        .DV (DV)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_divisor),
        .o_busy      (w_div_busy),
        .o_done      (w_div_done),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    assign w_q_dw    = w_div_q[DW-1:0];
    assign w_mean_dw = r_div_neg ? DW'(-w_q_dw) : w_q_dw;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ws    <= WINDOW_SIZE_RST;
            r_cfg_w     <= IMAGE_WIDTH_RST;
            r_cfg_h     <= IMAGE_HEIGHT_RST;
            r_dirty     <= 1'b1;
            r_col       <= '0;
            r_row       <= '0;
            r_cphase    <= '0;
            r_rphase    <= '0;
            r_oc        <= '0;
            r_cmod      <= '0;
            r_cols_used <= '0;
            r_rows_used <= '0;
            r_state     <= ST_IDLE;
            r_div_job   <= JOB_COLS;
            r_mean_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_div_start) begin
                r_div_job <= n_div_job;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_col    <= n_col;
                        r_row    <= n_row;
                        r_cphase <= n_cphase;
                        r_rphase <= n_rphase;
                        r_oc     <= n_oc;
                        r_cmod   <= n_cmod;
                        if (w_use) begin
                            r_state <= ST_ADD;
                        end
                    end else if (r_dirty && w_div_avail) begin
                        r_dirty <= 1'b0;
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    if (w_div_done) begin
                        case (r_div_job)
                            JOB_COLS: r_cols_used <= DIM_W'(w_div_q[DIM_W-1:0] * w_ws);
                            JOB_ROWS: r_rows_used <= DIM_W'(w_div_q[DIM_W-1:0] * w_ws);
                            JOB_COL: begin
                                r_oc    <= w_div_q[CW-1:0];
                                r_cmod  <= w_div_r[PHW-1:0];
                                r_state <= ST_IDLE;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_ADD: begin
                    if (w_add_go) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // any write invalidates the derived limits
            if (i_cfg_we) begin
                r_dirty <= 1'b1;
                case (i_cfg_index)
                    REG_WINDOW_SIZE:  r_cfg_ws <= i_cfg_data[WS_CFG_W-1:0];
                    REG_IMAGE_WIDTH:  r_cfg_w  <= i_cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: r_cfg_h  <= i_cfg_data[DIM_W-1:0];
                    default:          r_dirty  <= 1'b1;
                endcase
            end

            // hold a finished mean until the output register frees up
            if (w_div_done && r_div_job == JOB_MEAN) begin
                r_mean_pend <= 1'b1;
            end else if (r_mean_pend && w_out_free) begin
                r_mean_pend <= 1'b0;
            end

            if (r_mean_pend && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x     <= w_x;
            r_addr  <= r_oc;
            r_first <= w_first;
            r_last  <= w_last;
            r_flast <= w_flast;
        end
        if (w_div_start && n_div_job == JOB_MEAN) begin
            r_div_neg   <= w_sum[DW-1];
            r_div_flast <= r_flast;
        end
        if (r_mean_pend && w_out_free) begin
            r_out_mean <= OUT_W'(w_mean_dw);
            r_out_last <= r_div_flast;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mean_value = r_out_mean;
    assign o_frame_last = r_out_last;

    // A mean never completes while an earlier one still waits for the output.
    a_mean_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_done && r_div_job == JOB_MEAN) |-> !r_mean_pend)
        else $error("mean finished while previous mean still pending");

    // The row store never reads and writes in the same cycle.
    a_store_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_acc.rd_en && w_acc.wr_en))
        else $error("row store read and write overlap");

    // A sample inside a whole window is always followed by its add cycle.
    a_use_then_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_use) |=> (r_state == ST_ADD))
        else $error("accepted sample skipped its add cycle");

    // The divider is only started while idle.
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

endmodule

// ===== sim/mean_pooling_2d_tb.sv =====
// Self-checking testbench for the mean_pooling_2d streaming block.
// Depends on mp2_pkg and the mean_pooling_2d RTL; needs nothing else.
`timescale 1ns / 1ps

module mean_pooling_2d_tb;
    import mp2_pkg::*;

    localparam int MAX_COLS     = 1024;
    localparam int MAX_WIN      = 8;
    localparam int ITEM_TARGET  = 1800;
    // Padding for the divider and output pipeline; pad generously.
    localparam int LAT_PAD      = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1_500_000;

    // One pooled result as the block should present it.
    typedef struct {
        logic signed [OUT_W-1:0] mean;
        logic                    last;
    } pooled_mean_t;

    // Tracks the pooling position and per-column band sums, queues the means
    // each transfer should produce and checks them against the output.
    class mean_pool_tracker;
        logic [WS_CFG_W-1:0] window_reg;
        logic [DIM_W-1:0]    width_reg;
        logic [DIM_W-1:0]    height_reg;
        logic [IN_W-1:0]     band_sum [MAX_COLS];
        int unsigned         col_pos, row_pos, col_phase, row_phase;
        pooled_mean_t        pending_means[$];
        int unsigned         mismatch_count, mean_count;

        function new();
            window_reg     = WINDOW_SIZE_RST;
            width_reg      = IMAGE_WIDTH_RST;
            height_reg     = IMAGE_HEIGHT_RST;
            col_pos        = 0;
            row_pos        = 0;
            col_phase      = 0;
            row_phase      = 0;
            mismatch_count = 0;
            mean_count     = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v == 0)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_WINDOW_SIZE:  window_reg = val[WS_CFG_W-1:0];
                REG_IMAGE_WIDTH:  width_reg  = val;
                REG_IMAGE_HEIGHT: height_reg = val;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [IN_W-1:0] sample);
            int unsigned  ws, w, h, cols_used, rows_used, cp, rp, oc;
            int           area;
            logic [IN_W-1:0] sum;
            pooled_mean_t m;
            ws = clamp_dim(window_reg, MAX_WIN);
            w  = clamp_dim(width_reg, MAX_COLS);
            h  = clamp_dim(height_reg, HEIGHT_LIMIT);
            cols_used = (w / ws) * ws;
            rows_used = (h / ws) * ws;
            cp = (col_phase >= ws) ? 0 : col_phase;
            rp = (row_phase >= ws) ? 0 : row_phase;

            if (col_pos < cols_used && row_pos < rows_used) begin
                oc  = col_pos / ws;
                // First sample of a window overwrites the band entry.
                sum = (cp == 0 && rp == 0) ? sample : band_sum[oc] + sample;
                band_sum[oc] = sum;
                if (cp == ws - 1 && rp == ws - 1) begin
                    area   = ws * ws;
                    m.mean = $signed(sum) / area;
                    m.last = (col_pos == cols_used - 1 && row_pos == rows_used - 1);
                    pending_means.push_back(m);
                end
            end

            if (col_pos >= w - 1) begin
                col_pos   = 0;
                col_phase = 0;
                if (row_pos >= h - 1) begin
                    row_pos   = 0;
                    row_phase = 0;
                end else begin
                    row_pos++;
                    row_phase = (rp + 1 >= ws) ? 0 : rp + 1;
                end
            end else begin
                col_pos++;
                col_phase = (cp + 1 >= ws) ? 0 : cp + 1;
                row_phase = rp;
            end
        endfunction

        function void check_mean(logic signed [OUT_W-1:0] mean, logic last);
            pooled_mean_t want;
            mean_count++;
            if (pending_means.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: mean %0d last=%0b arrived with nothing pending",
                             mean, last);
            end else begin
                want = pending_means.pop_front();
                if (mean !== want.mean || last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch on mean %0d: expected %0d last=%0b, got %0d last=%0b",
                                 mean_count, want.mean, want.last, mean, last);
                end
            end
        endfunction
    endclass

    // Every block input starts at a known value.
    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data     = '0;
    logic                    i_in_valid     = 1'b0;
    logic                    o_in_ready;
    logic signed [IN_W-1:0]  i_sample_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready    = 1'b0;
    logic signed [OUT_W-1:0] o_mean_value;
    logic                    o_frame_last;

    mean_pool_tracker tracker = new();

    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;
    int unsigned samples_sent   = 0;
    int unsigned useful_samples = 0;
    int unsigned setting_count  = 0;
    int unsigned cycle_count    = 0;
    logic        hold_req       = 1'b0;
    logic        hold_used      = 1'b0;
    int unsigned hold_left      = 0;

    logic [IN_W-1:0] corner_samples [4] = '{32'h7FFF_FFFF, 32'h8000_0000,
                                            32'hFFFF_FFFF, 32'h0000_0000};

    mean_pooling_2d u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mean_value   (o_mean_value),
        .o_frame_last   (o_frame_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bound the run; a hung handshake ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d means still pending",
                     cycle_count, tracker.pending_means.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: check each transfer against the oldest pending mean, then
    // pick the ready level for the next cycle. The one-time hold-off is
    // counted here so the input keeps running while the output is blocked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_mean(o_mean_value, o_frame_last);
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_used) begin
            hold_used   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic set_idle_mode(input int unsigned mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
        endcase
    endtask

    // Wait for every pending mean, then for anything still inside the
    // divider that could not have produced a queued result.
    task automatic drain_means();
        while (tracker.pending_means.size() != 0)
            @(posedge i_clk);
        repeat (LAT_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
    endtask

    // Registers change only at a frame boundary with the block drained, so
    // no band entry is ever read before the current window wrote it.
    task automatic load_setting(input int unsigned ws, input int unsigned w,
                                input int unsigned h);
        drain_means();
        write_reg(REG_WINDOW_SIZE, ws);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        i_cfg_we <= 1'b0;
        setting_count++;
    endtask

    // Offer one sample, optionally after idle cycles; return at its transfer.
    task automatic send_sample(input logic [IN_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= v;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        tracker.note_sample(v);
        samples_sent++;
    endtask

    // Send whole frames of random samples under the current setting.
    task automatic stream_frames(input int unsigned frames);
        int unsigned     ws, w, h, len;
        logic [IN_W-1:0] v;
        ws  = tracker.clamp_dim(tracker.window_reg, MAX_WIN);
        w   = tracker.clamp_dim(tracker.width_reg, MAX_COLS);
        h   = tracker.clamp_dim(tracker.height_reg, HEIGHT_LIMIT);
        len = w * h;
        repeat (frames * len) begin
            case ($urandom_range(0, 3))
                0: v = $urandom_range(0, 200) - 100;
                1: v = corner_samples[$urandom_range(0, 3)];
                default: v = $urandom();
            endcase
            send_sample(v);
        end
        i_in_valid <= 1'b0;
        if (w >= ws && h >= ws)
            useful_samples += frames * len;
    endtask

    initial begin
        logic [IN_W-1:0] wrap_frame [8];
        int unsigned     extremes [5][3];
        int unsigned     ws, w, h, ws_raw, w_raw, h_raw, frames, phase, k;

        // Window A sums four maxima and wraps to -4; window B sums to -1 and
        // must truncate toward zero, not floor.
        wrap_frame = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000};
        // Register extremes and out-of-range codes; the last three form no whole
        // window, so the block drops all of their samples.
        extremes = '{'{1, 1024, 1}, '{8, 8, 8}, '{15, 2047, 0},
                     '{9, 0, 2047}, '{8, 1, 1024}};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: wrap and truncation, single-sample windows at the field
        // extremes, then a frame whose last column and row are partial.
        set_idle_mode(0);
        load_setting(2, 4, 2);
        foreach (wrap_frame[i])
            send_sample(wrap_frame[i]);
        i_in_valid <= 1'b0;

        load_setting(1, 2, 1);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0001);
        i_in_valid <= 1'b0;

        load_setting(2, 5, 3);
        for (k = 0; k < 15; k++)
            send_sample(corner_samples[k % 4] ^ (k[0] ? 32'hAAAA_AAAA : 32'h5555_5555));
        i_in_valid <= 1'b0;

        // Back-pressure: block the output for a long stretch while input
        // keeps coming so the block fills and must stall its input.
        load_setting(2, 8, 8);
        hold_req <= 1'b1;
        stream_frames(1);

        for (k = 0; k < 5; k++) begin
            set_idle_mode(k + 1);
            load_setting(extremes[k][0], extremes[k][1], extremes[k][2]);
            stream_frames(1);
        end

        // Random settings, mostly small frames that pool; a few too narrow
        // to form a window at all.
        phase = 0;
        while (useful_samples < ITEM_TARGET) begin
            set_idle_mode(phase);
            ws = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_WIN) : $urandom_range(1, 4);
            w  = ws * $urandom_range(1, 3) + $urandom_range(0, ws - 1);
            h  = ws * $urandom_range(1, 2) + $urandom_range(0, ws - 1);
            if (ws > 1 && $urandom_range(0, 9) == 0)
                w = $urandom_range(1, ws - 1);
            // Alternate legal codes with the ones that clamp to the same value.
            ws_raw = ws;
            if (ws == 1 && $urandom_range(0, 1) == 1)
                ws_raw = 0;
            if (ws == MAX_WIN && $urandom_range(0, 1) == 1)
                ws_raw = $urandom_range(MAX_WIN + 1, 15);
            w_raw = (w == 1 && $urandom_range(0, 1) == 1) ? 0 : w;
            h_raw = (h == 1 && $urandom_range(0, 1) == 1) ? 0 : h;
            frames = (w * h > 200) ? 1 : $urandom_range(1, 3);
            load_setting(ws_raw, w_raw, h_raw);
            stream_frames(frames);
            phase++;
        end

        drain_means();
        $display("covered %0d samples (%0d in pooling frames) and %0d means over %0d settings",
                 samples_sent, useful_samples, tracker.mean_count, setting_count);
        $display("windows 1..8 with clamped codes, sizes up to 1024, four idle mixes, one hold-off");
        if (tracker.mismatch_count == 0 && tracker.pending_means.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d means never arrived",
                     tracker.mismatch_count, tracker.pending_means.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
